// ===== src/ocvsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// OCV to state-of-charge package
// Widths, the voltage/percent breakpoint table and the divider stage payload
// shared by the interpolator and its divider.
// ----------------------------------------------------------------------------
package ocvsoc_pkg;

  // Field widths of the item and the result.
  localparam int MV_W  = 16;
  localparam int PCT_W = 7;

  // Breakpoint table: voltages rise, percents never fall.
  localparam int TABLE_POINTS = 12;
  localparam int BREAKPOINTS  = 12;

  // Number of leading table points in use (at least one, at most the table).
  localparam int PTS_USED = (BREAKPOINTS > TABLE_POINTS) ? TABLE_POINTS :
                            (BREAKPOINTS < 1) ? 1 : BREAKPOINTS;

  localparam logic [MV_W-1:0] PT_MV [TABLE_POINTS] = '{
    16'd2500, 16'd3000, 16'd3300, 16'd3500, 16'd3600, 16'd3650,
    16'd3700, 16'd3750, 16'd3850, 16'd3950, 16'd4100, 16'd4200
  };

  localparam logic [PCT_W-1:0] PT_PCT [TABLE_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd75, 7'd90, 7'd98, 7'd100
  };

  // Highest percent that the table can return.
  localparam logic [PCT_W-1:0] PCT_MAX = PT_PCT[PTS_USED-1];

  // Widest segment of the table in millivolts.
  function automatic int max_seg_mv();
    int m;
    m = 1;
    for (int i = 0; i + 1 < TABLE_POINTS; i++) begin
      if (int'(PT_MV[i+1]) - int'(PT_MV[i]) > m) begin
        m = int'(PT_MV[i+1]) - int'(PT_MV[i]);
      end
    end
    return m;
  endfunction

  // Offset into a segment and segment width both fit in OFF_W bits.
  localparam int OFF_W  = $clog2(max_seg_mv() + 1);
  // Product of offset and percent step.
  localparam int PROD_W = OFF_W + PCT_W;
  // The quotient never exceeds the percent step, so it fits a percent.
  localparam int QUO_W  = PCT_W;

  // Payload that travels down the divider stages.
  typedef struct packed {
    logic [PROD_W-1:0] rem;   // partial remainder
    logic [OFF_W-1:0]  dv;    // segment width (divisor), never zero
    logic [PCT_W-1:0]  lp;    // left breakpoint percent
    logic [QUO_W-1:0]  quo;   // quotient bits found so far
  } div_stage_t;

endpackage

// ===== src/ocvsoc_divider.sv =====
// ----------------------------------------------------------------------------
// OCV interpolator divider
// Pipelined restoring divider: one quotient bit per register stage, so a new
// item may enter in every cycle.
// ----------------------------------------------------------------------------
module ocvsoc_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  ocvsoc_pkg::div_stage_t  in_i,
  output logic                    out_valid_o,
  output ocvsoc_pkg::div_stage_t  out_o
);

  localparam int NSTG = ocvsoc_pkg::QUO_W;

  logic                   valid_q [NSTG+1];
  ocvsoc_pkg::div_stage_t stage_q [NSTG+1];

  // Entry of the row of stages.
  assign valid_q[0] = in_valid_i;
  assign stage_q[0] = in_i;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam int BIT = NSTG - 1 - k;

    logic [ocvsoc_pkg::PROD_W-1:0] trial;
    ocvsoc_pkg::div_stage_t        stage_d;

    // Try to subtract the divisor shifted up to this quotient bit.
    always_comb begin
      trial   = ocvsoc_pkg::PROD_W'(stage_q[k].dv) << BIT;
      stage_d = stage_q[k];
      if (stage_q[k].rem >= trial) begin
        stage_d.rem      = stage_q[k].rem - trial;
        stage_d.quo[BIT] = 1'b1;
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk_i) begin
      stage_q[k+1] <= stage_d;
    end
  end

  assign out_valid_o = valid_q[NSTG];
  assign out_o       = stage_q[NSTG];

endmodule

// ===== src/ocv_soc_interpolator.sv =====
// ----------------------------------------------------------------------------
// OCV to state-of-charge interpolator
// Maps a cell open-circuit voltage in millivolts to a whole state-of-charge
// percentage by linear interpolation over a fixed breakpoint table.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle: busy_o is always low, and an
// item is accepted whenever start_i is high. Each item gives exactly one
// result, shown on charge_percent_o with done_o high for one cycle, in the
// order the items came in. Each item passes through the input, segment-select
// and multiply registers, the seven-stage restoring divider (one quotient bit
// per stage) and the output register, in that order. The receiver cannot
// stall the block, so results must be taken as they appear.
module ocv_soc_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ocvsoc_pkg::MV_W-1:0]  cell_millivolts_i,
  output logic                         done_o,
  output logic [ocvsoc_pkg::PCT_W-1:0] charge_percent_o
);

  localparam int LATENCY = ocvsoc_pkg::QUO_W + 4;

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Input stage.
  // ---------------------------------------------------------------------------
  logic                        in_valid_q;
  logic [ocvsoc_pkg::MV_W-1:0] mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mv_q <= cell_millivolts_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Segment select: compare against every breakpoint at once and pick the
  // first segment whose right voltage is not below the input.
  // ---------------------------------------------------------------------------
  logic                         found;
  logic [ocvsoc_pkg::PCT_W-1:0] lp_d;
  logic [ocvsoc_pkg::PCT_W-1:0] dp_d;
  logic [ocvsoc_pkg::OFF_W-1:0] dv_d;
  logic [ocvsoc_pkg::OFF_W-1:0] off_d;
  logic [ocvsoc_pkg::MV_W-1:0]  dv_raw;
  logic [ocvsoc_pkg::MV_W-1:0]  off_raw;

  always_comb begin
    found   = 1'b0;
    dv_raw  = '0;
    off_raw = '0;
    // Clamped cases: flat output with a unit divisor and no offset.
    lp_d    = ocvsoc_pkg::PT_PCT[ocvsoc_pkg::PTS_USED-1];
    dp_d    = '0;
    dv_d    = ocvsoc_pkg::OFF_W'(1);
    off_d   = '0;
    if (mv_q <= ocvsoc_pkg::PT_MV[0]) begin
      lp_d = ocvsoc_pkg::PT_PCT[0];
    end else begin
      for (int i = 0; i + 1 < ocvsoc_pkg::TABLE_POINTS; i++) begin
        if ((i + 1 < ocvsoc_pkg::PTS_USED) && !found &&
            (mv_q <= ocvsoc_pkg::PT_MV[i+1])) begin
          found   = 1'b1;
          lp_d    = ocvsoc_pkg::PT_PCT[i];
          dv_raw  = ocvsoc_pkg::PT_MV[i+1] - ocvsoc_pkg::PT_MV[i];
          off_raw = mv_q - ocvsoc_pkg::PT_MV[i];
          // A zero-width segment keeps the left percent.
          if (dv_raw != '0) begin
            dp_d  = ocvsoc_pkg::PT_PCT[i+1] - ocvsoc_pkg::PT_PCT[i];
            dv_d  = dv_raw[ocvsoc_pkg::OFF_W-1:0];
            off_d = off_raw[ocvsoc_pkg::OFF_W-1:0];
          end
        end
      end
    end
  end

  logic                         seg_valid_q;
  logic [ocvsoc_pkg::PCT_W-1:0] seg_lp_q;
  logic [ocvsoc_pkg::PCT_W-1:0] seg_dp_q;
  logic [ocvsoc_pkg::OFF_W-1:0] seg_dv_q;
  logic [ocvsoc_pkg::OFF_W-1:0] seg_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
    end else begin
      seg_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_lp_q  <= lp_d;
    seg_dp_q  <= dp_d;
    seg_dv_q  <= dv_d;
    seg_off_q <= off_d;
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: offset times percent step.
  // ---------------------------------------------------------------------------
  logic                   mul_valid_q;
  ocvsoc_pkg::div_stage_t mul_q;
  ocvsoc_pkg::div_stage_t mul_d;

  always_comb begin
    mul_d.rem = ocvsoc_pkg::PROD_W'(seg_off_q) * ocvsoc_pkg::PROD_W'(seg_dp_q);
    mul_d.dv  = seg_dv_q;
    mul_d.lp  = seg_lp_q;
    mul_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= seg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  // ---------------------------------------------------------------------------
  // Divide by the segment width.
  // ---------------------------------------------------------------------------
  logic                   div_valid;
  ocvsoc_pkg::div_stage_t div_out;

  ocvsoc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid_q),
    .in_i        (mul_q),
    .out_valid_o (div_valid),
    .out_o       (div_out)
  );

  // ---------------------------------------------------------------------------
  // Output stage: left percent plus quotient, masked to the result width.
  // ---------------------------------------------------------------------------
  logic [ocvsoc_pkg::PCT_W:0]   sum_w;
  logic                         done_q;
  logic [ocvsoc_pkg::PCT_W-1:0] charge_q;

  assign sum_w = {1'b0, div_out.lp} + {1'b0, div_out.quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    charge_q <= sum_w[ocvsoc_pkg::PCT_W-1:0];
  end

  assign done_o           = done_q;
  assign charge_percent_o = charge_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // Every accepted item produces a result after the fixed latency.
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted item produced no result at the expected latency");

  // No result appears without an item accepted the latency earlier.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without a matching accepted item");

  // The divider leaves a remainder below the divisor.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid |-> (div_out.rem < ocvsoc_pkg::PROD_W'(div_out.dv)))
    else $error("divider remainder not below the segment width");

  // The result never passes the top of the table.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (charge_percent_o <= ocvsoc_pkg::PCT_MAX))
    else $error("state of charge above the table maximum");

endmodule
